>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the 3x3 mine-count block.
// Needs nothing but a clock and an active-low reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked at every rising clock edge except while reset is asserted.
`define MCNT_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define MCNT_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCNT_ASSERT_RST(label, clk, rst_n, prop, msg)
`define MCNT_ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/mcnt_pkg.sv
// Types and constants of the 3x3 mine-count block.
// Used by the channel interfaces, the column-sum unit and the top level.
package mcnt_pkg;

    localparam logic [7:0] MINE_CHAR = 8'd33;
    localparam int MAX_ROWS = 1024;

    // Row position runs two rows past the grid while draining.
    localparam int ROW_W = 11;
    localparam int ROWM1_W = ROW_W - 1;
    localparam int OUT_POS_W = 10;
    localparam int CNT_W = 4;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;

    localparam logic CMD_CELL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Which of the three rows of a column enter its sum.
    typedef struct packed {
        logic mine;
        logic inc_r1;
        logic inc_r2;
    } row_sel_t;

endpackage

>>> rtl/core/mcnt_ifs.sv
// Valid/ready channel interfaces of the 3x3 mine-count block.
// Depends on mcnt_pkg for field widths.
interface mcnt_cell_if
    import mcnt_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] cell_char;

    modport source (output valid, output command, output cell_char, input ready);
    modport sink (input valid, input command, input cell_char, output ready);
endinterface

interface mcnt_count_if
    import mcnt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CNT_W-1:0]     mine_count;
    logic [OUT_POS_W-1:0] out_row;
    logic [OUT_POS_W-1:0] out_col;
    logic                 last_cell;

    modport source (output valid, output mine_count, output out_row, output out_col,
                    output last_cell, input ready);
    modport sink (input valid, input mine_count, input out_row, input out_col,
                  input last_cell, output ready);
endinterface

interface mcnt_cfg_if
    import mcnt_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/core/mcnt_colsum.sv
// Column line store and three-row column sum of the 3x3 mine-count block.
// Depends on mcnt_pkg for row_sel_t.
module mcnt_colsum
    import mcnt_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    localparam int COL_W = $clog2(MAX_COLS)
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_col,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_col,
    input  row_sel_t         sel,
    output logic [1:0]       col_sum
);

    // Each word holds the two previous rows of one column: bit 1 is the
    // newer row, bit 0 the older one.
    logic [1:0] mem [MAX_COLS];
    logic [1:0] rd_data_reg;
    logic [1:0] fwd_data_reg;
    logic       fwd_valid_reg;
    logic [1:0] word;
    logic [1:0] wr_word;

    assign word = fwd_valid_reg ? fwd_data_reg : rd_data_reg;
    assign wr_word = {sel.mine, word[1]};
    assign col_sum = {1'b0, sel.inc_r2 & word[0]} + {1'b0, sel.inc_r1 & word[1]}
                   + {1'b0, sel.mine};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_col] <= wr_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_col];
            fwd_data_reg <= wr_word;
        end
    end

    // A read of the column being written in the same cycle sees stale data,
    // so the written word is bypassed instead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_valid_reg <= wr_en && (wr_col == rd_col);
        end
    end

endmodule

>>> rtl/core/neighborhood_3x3_mine_count.sv
// Top level of the 3x3 mine-count block: position counters, column-sum
// pipeline, sliding window of column sums and output register.
// Depends on mcnt_pkg, mcnt_ifs, mcnt_colsum and assert_macros.svh.
//
//   channel   dir   handshake       payload
//   cells     in    valid / ready   command, cell_char
//   counts    out   valid / ready   mine_count, out_row, out_col, last_cell
//   cfg       in    valid / ready   index, wdata (0 = grid_rows, 1 = grid_cols)
//
// One request is taken per clock unless the window stage is held. A result that a
// request releases passes the registered read of the column line store and the
// window stage, then the output register. A grid of one row takes an extra
// internal step after its last cell, with cells.ready low.
// Reset clears the counters and valid flags; the line store needs no clearing.
// A stalled counts channel holds the window stage, which then holds cells.
`include "assert_macros.svh"

module neighborhood_3x3_mine_count
    import mcnt_pkg::*;
#(
    parameter int MAX_COLS = 1024
)(
    input logic           clk,
    input logic           rst_n,
    mcnt_cell_if.sink     cells,
    mcnt_count_if.source  counts,
    mcnt_cfg_if.sink      cfg
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int RESET_COLS = (MAX_COLS < 8) ? MAX_COLS : 8;
    localparam logic [COL_W-1:0] COLS_M1_RESET = COL_W'(RESET_COLS - 1);

    // Grid size, kept as size minus one after clamping to the legal range.
    logic [ROWM1_W-1:0] rows_m1_reg, rows_m1_next;
    logic [COL_W-1:0]   cols_m1_reg, cols_m1_next;

    // Position of the next step. After the last cell the position keeps
    // running through two virtual rows of empty cells, which drain the
    // remaining results one per flush request.
    logic [ROW_W-1:0]   pos_row_reg, pos_row_next;
    logic [COL_W-1:0]   pos_col_reg, pos_col_next;
    logic               done_reg, done_next;

    // Cell whose result the next emitting step releases.
    logic [ROWM1_W-1:0] orow_reg, orow_next;
    logic [COL_W-1:0]   ocol_reg, ocol_next;

    // Window stage.
    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_col_reg;
    row_sel_t           s1_sel_reg;
    logic               s1_c0_reg;
    logic               s1_cge2_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    logic [ROWM1_W-1:0] s1_orow_reg;
    logic [COL_W-1:0]   s1_ocol_reg;
    logic [1:0]         prev1_reg;
    logic [1:0]         prev2_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [CNT_W-1:0]     out_count_reg;
    logic [OUT_POS_W-1:0] out_row_reg;
    logic [OUT_POS_W-1:0] out_col_reg;
    logic                 out_last_reg;

    logic             cfg_fire;
    logic             auto_go;
    logic             out_free;
    logic             s1_move;
    logic             s0_can;
    logic             in_fire;
    logic             is_cell;
    logic             step;
    logic             mine;
    logic             col_last;
    logic             emit0;
    logic             last0;
    row_sel_t         sel0;
    logic [1:0]       col_sum;
    logic [CNT_W-1:0] count;

    assign cfg.ready = 1'b1;
    assign cfg_fire = cfg.valid;

    // In a one-row grid the first virtual step releases nothing, so it runs
    // on its own without waiting for a flush request.
    assign auto_go = done_reg && (pos_row_reg == ROW_W'(1)) && (pos_col_reg == '0);

    assign out_free = !out_valid_reg || counts.ready;
    assign s1_move = s1_valid_reg && (!s1_emit_reg || out_free);
    assign s0_can = !s1_valid_reg || s1_move;
    assign cells.ready = s0_can && !auto_go;
    assign in_fire = cells.valid && cells.ready;
    assign is_cell = (cells.command == CMD_CELL);

    // A cell counts only while cells are expected and a flush only while
    // draining; anything else is taken and dropped.
    assign step = auto_go ? s0_can
                          : (in_fire && (is_cell ? !done_reg : done_reg));
    assign mine = !done_reg && is_cell && (cells.cell_char == MINE_CHAR);

    assign col_last = (pos_col_reg == cols_m1_reg);
    assign emit0 = (pos_row_reg >= ROW_W'(2))
                || ((pos_row_reg == ROW_W'(1)) && (pos_col_reg != '0));
    assign last0 = (orow_reg == rows_m1_reg) && (ocol_reg == cols_m1_reg);

    assign sel0.mine = mine;
    assign sel0.inc_r1 = (pos_row_reg != '0);
    assign sel0.inc_r2 = (pos_row_reg >= ROW_W'(2));

    always_comb
    begin
        logic restart;
        restart = 1'b0;
        rows_m1_next = rows_m1_reg;
        cols_m1_next = cols_m1_reg;
        pos_row_next = pos_row_reg;
        pos_col_next = pos_col_reg;
        done_next = done_reg;
        orow_next = orow_reg;
        ocol_next = ocol_reg;
        if (cfg_fire)
        begin
            // A write to a known register abandons the grid in progress.
            case (cfg.index)
                REG_GRID_ROWS:
                begin
                    restart = 1'b1;
                    if (cfg.wdata == '0)
                        rows_m1_next = '0;
                    else if (cfg.wdata > CFG_DATA_W'(MAX_ROWS))
                        rows_m1_next = ROWM1_W'(MAX_ROWS - 1);
                    else
                        rows_m1_next = ROWM1_W'(cfg.wdata - 1'b1);
                end
                REG_GRID_COLS:
                begin
                    restart = 1'b1;
                    if (cfg.wdata == '0)
                        cols_m1_next = '0;
                    else if (32'(cfg.wdata) > 32'(MAX_COLS))
                        cols_m1_next = COL_W'(MAX_COLS - 1);
                    else
                        cols_m1_next = COL_W'(cfg.wdata - 1'b1);
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
        else if (step)
        begin
            if (emit0 && last0)
            begin
                // The final result of the grid: the next request starts anew.
                restart = 1'b1;
            end
            else
            begin
                if (col_last)
                begin
                    pos_col_next = '0;
                    pos_row_next = pos_row_reg + 1'b1;
                    if (!done_reg && (pos_row_reg == {1'b0, rows_m1_reg}))
                        done_next = 1'b1;
                end
                else
                begin
                    pos_col_next = pos_col_reg + 1'b1;
                end
                if (emit0)
                begin
                    if (ocol_reg == cols_m1_reg)
                    begin
                        ocol_next = '0;
                        orow_next = orow_reg + 1'b1;
                    end
                    else
                    begin
                        ocol_next = ocol_reg + 1'b1;
                    end
                end
            end
        end
        if (restart)
        begin
            pos_row_next = '0;
            pos_col_next = '0;
            done_next = 1'b0;
            orow_next = '0;
            ocol_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m1_reg <= ROWM1_W'(7);
            cols_m1_reg <= COLS_M1_RESET;
            pos_row_reg <= '0;
            pos_col_reg <= '0;
            done_reg <= 1'b0;
            orow_reg <= '0;
            ocol_reg <= '0;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rows_m1_reg <= rows_m1_next;
            cols_m1_reg <= cols_m1_next;
            pos_row_reg <= pos_row_next;
            pos_col_reg <= pos_col_next;
            done_reg <= done_next;
            orow_reg <= orow_next;
            ocol_reg <= ocol_next;
            if (step)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move && s1_emit_reg)
                out_valid_reg <= 1'b1;
            else if (counts.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // The line store keeps the two previous rows per column and returns the
    // three-row sum of the column centered one row above the step.
    mcnt_colsum #(
        .MAX_COLS (MAX_COLS)
    ) u_colsum (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (step),
        .rd_col  (pos_col_reg),
        .wr_en   (s1_move),
        .wr_col  (s1_col_reg),
        .sel     (s1_sel_reg),
        .col_sum (col_sum)
    );

    // A step at column zero releases the last cell of the row above, built
    // from the two previous column sums alone; any other step releases the
    // cell one column back, whose left column is absent at the left edge.
    always_comb
    begin
        if (s1_c0_reg)
        begin
            count = {2'b00, (cols_m1_reg != '0) ? prev2_reg : 2'b00}
                  + {2'b00, prev1_reg};
        end
        else
        begin
            count = {2'b00, s1_cge2_reg ? prev2_reg : 2'b00}
                  + {2'b00, prev1_reg} + {2'b00, col_sum};
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            s1_col_reg <= pos_col_reg;
            s1_sel_reg <= sel0;
            s1_c0_reg <= (pos_col_reg == '0);
            s1_cge2_reg <= (pos_col_reg >= COL_W'(2));
            s1_emit_reg <= emit0;
            s1_last_reg <= last0;
            s1_orow_reg <= orow_reg;
            s1_ocol_reg <= ocol_reg;
        end
        if (s1_move)
        begin
            prev2_reg <= prev1_reg;
            prev1_reg <= col_sum;
        end
        if (s1_move && s1_emit_reg)
        begin
            out_count_reg <= count;
            out_row_reg <= OUT_POS_W'(s1_orow_reg);
            out_col_reg <= OUT_POS_W'(s1_ocol_reg);
            out_last_reg <= s1_last_reg;
        end
    end

    assign counts.valid = out_valid_reg;
    assign counts.mine_count = out_count_reg;
    assign counts.out_row = out_row_reg;
    assign counts.out_col = out_col_reg;
    assign counts.last_cell = out_last_reg;

    // A result waiting on a full output register must stay in the window stage.
    `MCNT_ASSERT_RST(a_window_holds, clk, rst_n,
        s1_valid_reg && s1_emit_reg && out_valid_reg && !counts.ready
            |=> s1_valid_reg && $stable(s1_orow_reg) && $stable(s1_ocol_reg),
        "window stage lost a stalled result")
    // Draining only starts once the position has left the grid.
    `MCNT_ASSERT_RST(a_done_past_grid, clk, rst_n,
        done_reg |-> pos_row_reg > {1'b0, rows_m1_reg},
        "drain flag set inside the grid")
    // The flagged result belongs to the bottom row.
    `MCNT_ASSERT_RST(a_last_row, clk, rst_n,
        out_valid_reg && out_last_reg |-> out_row_reg == OUT_POS_W'(rows_m1_reg),
        "last cell flagged off the bottom row")
    // A result that the counts channel has not taken stays as it is.
    `MCNT_ASSERT_RST(a_count_held, clk, rst_n,
        out_valid_reg && !counts.ready
            |=> out_valid_reg && $stable(out_count_reg) && $stable(out_row_reg)
                && $stable(out_col_reg) && $stable(out_last_reg),
        "count changed while stalled")

endmodule

>>> tb/neighborhood_3x3_mine_count_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 3x3 mine-count block, with its own predictor and checker.
// Depends on mcnt_pkg, the mcnt channel interfaces and the neighborhood_3x3_mine_count RTL.

module neighborhood_3x3_mine_count_test;
    import mcnt_pkg::*;

    localparam int GRID_MAX_COLS = 1024;
    // A result passes the window stage and the output register after its request,
    // and a one-row grid adds an internal step. The settle time leaves a clear margin.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_REQUESTS = 400;
    localparam int REPORT_LINES = 40;

    // One neighborhood count as the block should deliver it.
    typedef struct packed {
        logic [CNT_W-1:0]     mine_count;
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
        logic                 last;
    } mine_count_t;

    logic clk;
    logic rst_n;

    mcnt_cell_if  cells_ch();
    mcnt_count_if counts_ch();
    mcnt_cfg_if   cfg_ch();

    neighborhood_3x3_mine_count #(
        .MAX_COLS(GRID_MAX_COLS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cells  (cells_ch),
        .counts (counts_ch),
        .cfg    (cfg_ch)
    );

    // The predictor keeps a copy of both grid-size registers as written. It
    // also keeps the mine bits of the four most recent rows, indexed by row
    // modulo four, and the input and output raster positions.
    logic [CFG_DATA_W-1:0] rows_setting;
    logic [CFG_DATA_W-1:0] cols_setting;
    bit                    mine_lines [4][GRID_MAX_COLS];
    int unsigned           in_row;
    int unsigned           in_col;
    int unsigned           out_row_pos;
    int unsigned           out_col_pos;
    bit                    cells_done;

    // Counts the predictor expects, oldest first.
    mine_count_t pending_counts[$];

    int mismatch_count;
    int live_requests;   // requests that the block acts on, ignored ones excluded
    int cycle_count;
    bit send_idle;
    bit take_idle;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Watchdog: a hung handshake or a count that never arrives ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // A register value of zero means one, and values above the maximum saturate.
    function automatic int unsigned clamp_size(input logic [CFG_DATA_W-1:0] value,
                                               input int unsigned limit);
        if (value == '0)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    function automatic void restart_grid();
        in_row = 0;
        in_col = 0;
        out_row_pos = 0;
        out_col_pos = 0;
        cells_done = 1'b0;
    endfunction

    // Computes the count at the current output position and queues it. The
    // whole in-grid neighborhood of that cell has already arrived, and cells
    // beyond the grid edge are treated as empty.
    function automatic void release_count();
        int unsigned rows;
        int unsigned cols;
        int unsigned mines;
        int          rr;
        int          cc;
        mine_count_t res;
        rows = clamp_size(rows_setting, MAX_ROWS);
        cols = clamp_size(cols_setting, GRID_MAX_COLS);
        mines = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            rr = int'(out_row_pos) + dr;
            if (rr < 0 || rr >= int'(rows))
                continue;
            for (int dc = -1; dc <= 1; dc++) begin
                cc = int'(out_col_pos) + dc;
                if (cc < 0 || cc >= int'(cols))
                    continue;
                mines += mine_lines[rr % 4][cc];
            end
        end
        res.mine_count = CNT_W'(mines);
        res.row = OUT_POS_W'(out_row_pos);
        res.col = OUT_POS_W'(out_col_pos);
        res.last = (out_row_pos == rows - 1) && (out_col_pos == cols - 1);
        pending_counts.insert(pending_counts.size(), res);

        // The last cell of the grid also starts a new grid.
        if (res.last)
            restart_grid();
        else if (out_col_pos + 1 >= cols) begin
            out_col_pos = 0;
            out_row_pos++;
        end
        else
            out_col_pos++;
    endfunction

    // Applies one accepted request to the predictor. A cell releases the count
    // one row and one cell behind it. After the last cell, each flush releases
    // one count. A cell that arrives while the grid drains is ignored, and so is
    // a flush that arrives while cells are still expected.
    function automatic void predict_request(input logic cmd, input logic [7:0] ch);
        int unsigned rows;
        int unsigned cols;
        bit          releases;
        rows = clamp_size(rows_setting, MAX_ROWS);
        cols = clamp_size(cols_setting, GRID_MAX_COLS);
        if (cmd == CMD_FLUSH) begin
            if (cells_done) begin
                live_requests++;
                release_count();
            end
            return;
        end
        if (cells_done)
            return;
        live_requests++;
        mine_lines[in_row % 4][in_col] = (ch == MINE_CHAR);
        releases = (in_row * cols + in_col >= cols + 1);
        if (in_col + 1 >= cols) begin
            in_col = 0;
            if (in_row + 1 >= rows)
                cells_done = 1'b1;
            else
                in_row++;
        end
        else
            in_col++;
        if (releases)
            release_count();
    endfunction

    // Each task below is entered and left at a falling edge. A request that is
    // to follow at once keeps valid high without a second assignment.
    task automatic send_request(input logic cmd, input logic [7:0] ch);
        int gap;
        gap = send_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            cells_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cells_ch.valid <= 1'b1;
        cells_ch.command <= cmd;
        cells_ch.cell_char <= ch;
        do @(posedge clk); while (cells_ch.ready !== 1'b1);
        predict_request(cmd, ch);
        @(negedge clk);
    endtask

    // Holds the cell channel quiet until every predicted count has arrived.
    // At least one falling edge passes, so the next request drives valid anew.
    task automatic drain_results();
        cells_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_counts.size() != 0);
    endtask

    // Register writes happen only with the block idle. The block may still be
    // busy with a cell that releases nothing, so a short settle time follows
    // the drain. Every write abandons the grid in progress.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        if (idx == REG_GRID_ROWS)
            rows_setting = value;
        else
            cols_setting = value;
        restart_grid();
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_char();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] cell_with_density(input int mine_pct);
        if ($urandom_range(1, 100) <= mine_pct)
            return MINE_CHAR;
        return random_char();
    endfunction

    // Feeds cells until the grid is complete, then flushes until the last count
    // is out. When noise_pct is nonzero, stray flushes go in among the cells and
    // stray cells among the flushes, and all of them must be ignored. The grid
    // can stop early at abandon_at, or pause for a full drain at pause_at.
    task automatic run_grid(input int mine_pct, input int noise_pct,
                            input int abandon_at, input int pause_at);
        int sent;
        sent = 0;
        while (!cells_done) begin
            if (sent == abandon_at)
                return;
            if (sent == pause_at)
                drain_results();
            if ($urandom_range(1, 100) <= noise_pct)
                send_request(CMD_FLUSH, random_char());
            send_request(CMD_CELL, cell_with_density(mine_pct));
            sent++;
        end
        while (cells_done) begin
            if ($urandom_range(1, 100) <= noise_pct)
                send_request(CMD_CELL, random_char());
            send_request(CMD_FLUSH, random_char());
        end
        if (noise_pct > 0 && $urandom_range(0, 3) == 0)
            send_request(CMD_FLUSH, random_char());
    endtask

    // The 8 x 8 grid size from reset: the tenth cell releases the count for
    // the first cell. The next register write then abandons this grid.
    task automatic test_reset_grid_size();
        for (int i = 0; i < 10; i++)
            send_request(CMD_CELL, (i % 3 == 0) ? MINE_CHAR : 8'(i * 29));
    endtask

    // Zero in both registers gives a 1 x 1 grid. This also covers a cell sent
    // while the grid drains, a flush sent while a cell is expected, and the
    // characters right around the mine character; both extreme bytes ride on flushes or ignored cells.
    task automatic test_single_cell_grid();
        write_register(REG_GRID_ROWS, '0);
        write_register(REG_GRID_COLS, '0);
        send_request(CMD_FLUSH, 8'hFF);
        send_request(CMD_CELL, MINE_CHAR);
        send_request(CMD_CELL, 8'hFF);
        send_request(CMD_FLUSH, 8'h00);
        send_request(CMD_CELL, 8'd32);
        send_request(CMD_FLUSH, MINE_CHAR);
        send_request(CMD_CELL, 8'd34);
        send_request(CMD_FLUSH, 8'h00);
    endtask

    // A 3 x 3 grid that is all mines gives every count from corner to center.
    task automatic test_all_mines_grid();
        write_register(REG_GRID_ROWS, 11'd3);
        write_register(REG_GRID_COLS, 11'd3);
        run_grid(100, 0, -1, -1);
    endtask

    // The largest row count, paired with a single column. A register value
    // above the maximum must saturate, and the last row index must reach the
    // top of the output field.
    task automatic test_size_extremes();
        write_register(REG_GRID_ROWS, 11'd2047);
        write_register(REG_GRID_COLS, 11'd1);
        run_grid(40, 0, -1, -1);
    endtask

    // Mostly small grid sizes, with a few moderate ones and an occasional zero.
    function automatic logic [CFG_DATA_W-1:0] random_size();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        if (pick < 75)
            return CFG_DATA_W'($urandom_range(1, 5));
        if (pick < 95)
            return CFG_DATA_W'($urandom_range(6, 12));
        return CFG_DATA_W'($urandom_range(13, 40));
    endfunction

    // Complete grids of random size and content make up most of the stimulus.
    // Some grids are abandoned, some pause midway, and some are run again
    // without a new register write.
    task automatic test_random_grids();
        int          goal;
        int          choice;
        int          mine_pct;
        int          noise_pct;
        int          abandon_at;
        int          pause_at;
        int unsigned grid_cells;
        bit          abandoned;
        goal = live_requests + RANDOM_REQUESTS;
        abandoned = 1'b0;
        while (live_requests < goal) begin
            send_idle = ($urandom_range(0, 3) != 0);
            take_idle = ($urandom_range(0, 3) != 0);
            choice = $urandom_range(0, 9);
            if (abandoned && choice == 9)
                choice = 0;
            if (choice <= 7)
                write_register(REG_GRID_ROWS, random_size());
            if (choice <= 6 || choice == 8)
                write_register(REG_GRID_COLS, random_size());
            grid_cells = clamp_size(rows_setting, MAX_ROWS)
                       * clamp_size(cols_setting, GRID_MAX_COLS);
            case ($urandom_range(0, 5))
                0: mine_pct = 0;
                1: mine_pct = 100;
                default: mine_pct = $urandom_range(10, 60);
            endcase
            noise_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            abandon_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, grid_cells - 1) : -1;
            pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, grid_cells - 1) : -1;
            abandoned = (abandon_at >= 0);
            run_grid(mine_pct, noise_pct, abandon_at, pause_at);
        end
    endtask

    // Count channel: the ready gap is drawn anew for each count, and each count
    // is checked against the oldest prediction.
    initial begin
        mine_count_t seen;
        mine_count_t want;
        int          gap;
        counts_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            gap = take_idle ? $urandom_range(0, 3) : 0;
            if (gap > 0) begin
                counts_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            counts_ch.ready <= 1'b1;
            do @(posedge clk); while (counts_ch.valid !== 1'b1);
            seen.mine_count = counts_ch.mine_count;
            seen.row = counts_ch.out_row;
            seen.col = counts_ch.out_col;
            seen.last = counts_ch.last_cell;
            if (pending_counts.size() == 0)
                report_mismatch($sformatf("count %0d at row %0d col %0d with none expected",
                                          seen.mine_count, seen.row, seen.col));
            else begin
                want = pending_counts.pop_front();
                if (seen.mine_count !== want.mine_count)
                    report_mismatch($sformatf("row %0d col %0d: mine_count %0d, expected %0d",
                                              want.row, want.col, seen.mine_count,
                                              want.mine_count));
                if (seen.row !== want.row)
                    report_mismatch($sformatf("out_row %0d, expected %0d",
                                              seen.row, want.row));
                if (seen.col !== want.col)
                    report_mismatch($sformatf("out_col %0d, expected %0d",
                                              seen.col, want.col));
                if (seen.last !== want.last)
                    report_mismatch($sformatf("row %0d col %0d: last_cell %0b, expected %0b",
                                              want.row, want.col, seen.last, want.last));
            end
            @(negedge clk);
        end
    end

    // Stimulus: reset once, then the directed tests, then the random grids,
    // then a drain and a short quiet period before the verdict.
    initial begin
        rst_n = 1'b0;
        cells_ch.valid = 1'b0;
        cells_ch.command = CMD_CELL;
        cells_ch.cell_char = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_GRID_ROWS;
        cfg_ch.wdata = '0;
        send_idle = 1'b1;
        take_idle = 1'b1;
        mismatch_count = 0;
        live_requests = 0;
        cycle_count = 0;
        rows_setting = 11'd8;
        cols_setting = 11'd8;
        restart_grid();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_grid_size();
        test_single_cell_grid();
        test_all_mines_grid();
        test_size_extremes();
        test_random_grids();

        drain_results();
        repeat (2 * SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
